@@ sv/jdc_pkg.sv @@
// Shared package of the Julian day to calendar date unit.
// Holds field widths, calendar constants, exact reciprocal constants and the month table.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package jdc_pkg;

    localparam int NUM_STAGES = 8;

    // Field widths.
    localparam int DAY_NUMBER_W    = 23;
    localparam int SECOND_OF_DAY_W = 17;
    localparam int YEAR_W          = 16;
    localparam int MONTH_W         = 4;
    localparam int DAY_W           = 5;
    localparam int HOUR_W          = 5;
    localparam int MINUTE_W        = 6;
    localparam int SECOND_W        = 6;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // Calendar constants.
    localparam logic [22:0] GREG_SWITCH_DAY = 23'd2299161;
    localparam logic [22:0] GREG_EPOCH      = 23'd1867216;
    localparam logic [23:0] JB_OFFSET       = 24'd1524;
    localparam logic [29:0] JC_BIAS         = 30'd12210;
    localparam logic signed [15:0] YEAR_OFFSET = 16'sd4715;
    localparam logic [16:0] LAST_SECOND     = 17'd86399;

    // Exact floor division by a constant: floor(n / d) == (n * ceil(2^s / d)) >> s
    // for every n below 2^k when s = k + ceil(log2(d)).
    localparam int ALPHA_NUM_W   = 25;
    localparam int ALPHA_SHIFT   = 43;
    localparam int ALPHA_RECIP_W = 26;
    localparam logic [ALPHA_RECIP_W-1:0] ALPHA_RECIP =
        ALPHA_RECIP_W'(((64'd1 << ALPHA_SHIFT) + 64'd146096) / 64'd146097);

    localparam int JC_NUM_W   = 30;
    localparam int JC_SHIFT   = 46;
    localparam int JC_RECIP_W = 31;
    localparam logic [JC_RECIP_W-1:0] JC_RECIP =
        JC_RECIP_W'(((64'd1 << JC_SHIFT) + 64'd36524) / 64'd36525);

    localparam int HOUR_SHIFT   = 29;
    localparam int HOUR_RECIP_W = 18;
    localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP =
        HOUR_RECIP_W'(((64'd1 << HOUR_SHIFT) + 64'd3599) / 64'd3600);

    localparam int REM_W       = 12;
    localparam int MIN_SHIFT   = 18;
    localparam int MIN_RECIP_W = 13;
    localparam logic [MIN_RECIP_W-1:0] MIN_RECIP =
        MIN_RECIP_W'(((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60);

    // Per-stage control handed from the pipeline control to the data paths.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } pipe_ctrl_t;

    // Days before month index k counted from March: floor(30.6001 * k).
    function automatic logic [8:0] month_base(input logic [3:0] k);
        logic [8:0] base;
        unique case (k)
            4'd0:  base = 9'd0;
            4'd1:  base = 9'd30;
            4'd2:  base = 9'd61;
            4'd3:  base = 9'd91;
            4'd4:  base = 9'd122;
            4'd5:  base = 9'd153;
            4'd6:  base = 9'd183;
            4'd7:  base = 9'd214;
            4'd8:  base = 9'd244;
            4'd9:  base = 9'd275;
            4'd10: base = 9'd306;
            4'd11: base = 9'd336;
            4'd12: base = 9'd367;
            4'd13: base = 9'd397;
            4'd14: base = 9'd428;
            4'd15: base = 9'd459;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

@@ sv/julian_day_to_calendar_date_unit.sv @@
// Throughput: one transaction per cycle, limited only by the downstream tready.
// Every stage register holds one transaction, so a stall fills bubbles and loses nothing.
// Reset (rst_n low, asynchronous) clears the stage valid bits only; there is no clearing pass.
`default_nettype none

// Top level of the Julian day to calendar date unit.
//
// Each input transaction carries a civil Julian day number and the seconds since
// midnight. Day numbers from 2299161 onwards are converted in the Gregorian
// calendar, earlier ones in the Julian calendar, and there is no year zero.
// Seconds above 86399 saturate to 23:59:59 without moving the date.
//
// The date path runs the classical algorithm with every floating division turned
// into an exact integer floor. Divisions by 146097 and 36525 use reciprocal
// multiplication with enough fraction bits to be exact over the whole input
// range, each multiplier in a stage of its own. The month division by 30.6001
// is replaced by comparisons against a small table of month starts, since the
// day within the year counted from March is confined to a few hundred values.
// The time path divides by 3600 and 60 in the same way and is then delayed so
// that both halves meet in the output register.
//
// The last stage register is the output register: each stage is loaded whenever
// it is empty or its contents move on, so new transactions keep entering while a
// finished result waits for the downstream side.

module julian_day_to_calendar_date_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [22:0] day_number, [39:23] second_of_day
    input  wire logic [39:0] s_axis_tdata,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] year, [19:16] month, [24:20] day, [29:25] hour, [35:30] minute,
    // [41:36] second, [47:42] zero
    output logic [47:0]      m_axis_tdata
);

    localparam int N = jdc_pkg::NUM_STAGES;

    jdc_pkg::pipe_ctrl_t ctrl;

    logic signed [15:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;

    jdc_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .out_ready (m_axis_tready),
        .ctrl      (ctrl),
        .in_ready  (s_axis_tready)
    );

    jdc_date_path u_date (
        .clk        (clk),
        .ctrl       (ctrl),
        .day_number (s_axis_tdata[22:0]),
        .year       (year),
        .month      (month),
        .day        (day)
    );

    jdc_time_path u_time (
        .clk           (clk),
        .ctrl          (ctrl),
        .second_of_day (s_axis_tdata[39:23]),
        .hour          (hour),
        .minute        (minute),
        .second        (second)
    );

    assign m_axis_tvalid = ctrl.valid[N-1];
    assign m_axis_tdata  = {6'd0, second, minute, hour, day, month, year};

`ifndef ASSERT_OFF
    // A ready downstream side leaves no stage stalled, so the input must be ready too.
    a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input not ready although the output side is ready");

    // Every delivered transaction holds a valid date and time.
    a_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1)
                          && (hour <= 5'd23) && (minute <= 6'd59)
                          && (second <= 6'd59) && (year != 16'sd0))
        else $error("output fields out of range");

    // A result only appears when the stage before the output held a transaction.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !$past(m_axis_tvalid) |-> $past(ctrl.valid[N-2]))
        else $error("output valid without a transaction in the previous stage");
`endif

endmodule

`default_nettype wire

@@ sv/jdc_pipe_ctrl.sv @@
// Valid bits and stage load enables of the conversion pipeline.
// Depends on jdc_pkg.
`default_nettype none

module jdc_pipe_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              out_ready,
    output jdc_pkg::pipe_ctrl_t    ctrl,
    output logic                   in_ready
);

    localparam int N = jdc_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N-1:0] ready;

    // A stage takes new contents when it is empty or its contents move on.
    always_comb
    begin
        ready[N-1] = !valid_reg[N-1] || out_ready;
        for (int i = N - 2; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ready[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int i = 1; i < N; i++)
        begin
            if (ready[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load  = ready;
    assign ctrl.valid = valid_reg;
    assign in_ready   = ready[0];

endmodule

`default_nettype wire

@@ sv/jdc_date_path.sv @@
// Date data path: day number to year, month and day over eight register stages.
// Depends on jdc_pkg.
`default_nettype none

module jdc_date_path (
    input  wire logic                  clk,
    input  wire jdc_pkg::pipe_ctrl_t   ctrl,
    input  wire logic [22:0]           day_number,
    output logic signed [15:0]         year,
    output logic [3:0]                 month,
    output logic [4:0]                 day
);

    // Stage 0: Gregorian test and the numerator of the century correction.
    logic        greg_s0_reg, greg_s0_next;
    logic [22:0] jnum_s0_reg;
    logic [24:0] n1_s0_reg, n1_s0_next;
    logic [22:0] j_off;

    always_comb
    begin
        greg_s0_next = (day_number >= jdc_pkg::GREG_SWITCH_DAY);
        j_off        = day_number - jdc_pkg::GREG_EPOCH;
        n1_s0_next   = greg_s0_next ? ({j_off, 2'b00} - 25'd1) : '0;
    end

    // Stage 1: alpha = floor(n1 / 146097).
    logic        greg_s1_reg;
    logic [22:0] jnum_s1_reg;
    logic [7:0]  alpha_s1_reg, alpha_s1_next;
    logic [jdc_pkg::ALPHA_NUM_W+jdc_pkg::ALPHA_RECIP_W-1:0] alpha_prod;

    always_comb
    begin
        alpha_prod    = n1_s0_reg * jdc_pkg::ALPHA_RECIP;
        alpha_s1_next = 8'(alpha_prod >> jdc_pkg::ALPHA_SHIFT);
    end

    // Stage 2: jb = ja + 1524.
    logic [23:0] jb_s2_reg, jb_s2_next;

    always_comb
    begin
        if (greg_s1_reg)
        begin
            jb_s2_next = 24'(jnum_s1_reg) + jdc_pkg::JB_OFFSET + 24'd1
                       + 24'(alpha_s1_reg) - 24'(alpha_s1_reg[7:2]);
        end
        else
        begin
            jb_s2_next = 24'(jnum_s1_reg) + jdc_pkg::JB_OFFSET;
        end
    end

    // Stage 3: numerator of the year count.
    logic [23:0] jb_s3_reg;
    logic [29:0] n3_s3_reg, n3_s3_next;

    assign n3_s3_next = 30'(jb_s2_reg) * 30'd100 - jdc_pkg::JC_BIAS;

    // Stage 4: jc = floor(n3 / 36525).
    logic [23:0] jb_s4_reg;
    logic [14:0] jc_s4_reg, jc_s4_next;
    logic [jdc_pkg::JC_NUM_W+jdc_pkg::JC_RECIP_W-1:0] jc_prod;

    always_comb
    begin
        jc_prod    = n3_s3_reg * jdc_pkg::JC_RECIP;
        jc_s4_next = 15'(jc_prod >> jdc_pkg::JC_SHIFT);
    end

    // Stage 5: day of the year counted from March, always within 123 to 488.
    logic [14:0] jc_s5_reg;
    logic [8:0]  jbd_s5_reg, jbd_s5_next;
    logic [23:0] jd;

    always_comb
    begin
        jd          = 24'(jc_s4_reg) * 24'd365 + 24'(jc_s4_reg[14:2]);
        jbd_s5_next = 9'(jb_s4_reg - jd);
    end

    // Stage 6: month index from the table thresholds, which rise with the index.
    logic [14:0] jc_s6_reg;
    logic [8:0]  jbd_s6_reg;
    logic [3:0]  je_s6_reg, je_s6_next;

    always_comb
    begin
        je_s6_next = '0;
        for (int k = 1; k < 16; k++)
        begin
            if (jbd_s5_reg > jdc_pkg::month_base(4'(k)))
            begin
                je_s6_next = 4'(k);
            end
        end
    end

    // Stage 7: final date fields.
    logic signed [15:0] year_reg, year_next;
    logic [3:0]         month_reg, month_next;
    logic [4:0]         day_reg, day_next;

    always_comb
    begin
        day_next   = 5'(jbd_s6_reg - jdc_pkg::month_base(je_s6_reg));
        month_next = je_s6_reg - 4'd1;
        if (month_next > 4'd12)
        begin
            month_next = month_next - 4'd12;
        end
        year_next = signed'(16'(jc_s6_reg)) - jdc_pkg::YEAR_OFFSET;
        if (month_next > 4'd2)
        begin
            year_next = year_next - 16'sd1;
        end
        // No year zero: 1 BC follows AD 1 directly.
        if (year_next <= 16'sd0)
        begin
            year_next = year_next - 16'sd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            greg_s0_reg <= greg_s0_next;
            jnum_s0_reg <= day_number;
            n1_s0_reg   <= n1_s0_next;
        end
        if (ctrl.load[1])
        begin
            greg_s1_reg  <= greg_s0_reg;
            jnum_s1_reg  <= jnum_s0_reg;
            alpha_s1_reg <= alpha_s1_next;
        end
        if (ctrl.load[2])
        begin
            jb_s2_reg <= jb_s2_next;
        end
        if (ctrl.load[3])
        begin
            jb_s3_reg <= jb_s2_reg;
            n3_s3_reg <= n3_s3_next;
        end
        if (ctrl.load[4])
        begin
            jb_s4_reg <= jb_s3_reg;
            jc_s4_reg <= jc_s4_next;
        end
        if (ctrl.load[5])
        begin
            jc_s5_reg  <= jc_s4_reg;
            jbd_s5_reg <= jbd_s5_next;
        end
        if (ctrl.load[6])
        begin
            jc_s6_reg  <= jc_s5_reg;
            jbd_s6_reg <= jbd_s5_reg;
            je_s6_reg  <= je_s6_next;
        end
        if (ctrl.load[7])
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
        end
    end

    assign year  = year_reg;
    assign month = month_reg;
    assign day   = day_reg;

endmodule

`default_nettype wire

@@ sv/jdc_time_path.sv @@
// Time data path: seconds of the day to hour, minute and second, aligned to the date path.
// Depends on jdc_pkg.
`default_nettype none

module jdc_time_path (
    input  wire logic                  clk,
    input  wire jdc_pkg::pipe_ctrl_t   ctrl,
    input  wire logic [16:0]           second_of_day,
    output logic [4:0]                 hour,
    output logic [5:0]                 minute,
    output logic [5:0]                 second
);

    localparam int N = jdc_pkg::NUM_STAGES;
    localparam int SECOND_OF_DAY_PROD_W = jdc_pkg::SECOND_OF_DAY_W + jdc_pkg::HOUR_RECIP_W;

    // Stage 0: out-of-range seconds saturate to the last second of the day.
    logic [16:0] secs_s0_reg, secs_s0_next;

    assign secs_s0_next = (second_of_day > jdc_pkg::LAST_SECOND) ?
                          jdc_pkg::LAST_SECOND : second_of_day;

    // Stage 1: hour = floor(s / 3600).
    logic [16:0] secs_s1_reg;
    logic [4:0]  hour_s1_reg, hour_s1_next;
    logic [SECOND_OF_DAY_PROD_W-1:0] hour_prod;

    always_comb
    begin
        hour_prod    = secs_s0_reg * jdc_pkg::HOUR_RECIP;
        hour_s1_next = 5'(hour_prod >> jdc_pkg::HOUR_SHIFT);
    end

    // Stage 2: seconds within the hour.
    logic [4:0]               hour_s2_reg;
    logic [jdc_pkg::REM_W-1:0] rem_s2_reg, rem_s2_next;

    assign rem_s2_next = jdc_pkg::REM_W'(secs_s1_reg - 17'(hour_s1_reg) * 17'd3600);

    // Stage 3: minute = floor(rem / 60).
    logic [4:0]               hour_s3_reg;
    logic [jdc_pkg::REM_W-1:0] rem_s3_reg;
    logic [5:0]               min_s3_reg, min_s3_next;
    logic [jdc_pkg::REM_W+jdc_pkg::MIN_RECIP_W-1:0] min_prod;

    always_comb
    begin
        min_prod    = rem_s2_reg * jdc_pkg::MIN_RECIP;
        min_s3_next = 6'(min_prod >> jdc_pkg::MIN_SHIFT);
    end

    // Stage 4 onwards: seconds, then delay to meet the date at the output stage.
    logic [5:0] sec_s4_next;
    logic [4:0] hour_dly_reg [4:N-1];
    logic [5:0] min_dly_reg  [4:N-1];
    logic [5:0] sec_dly_reg  [4:N-1];

    assign sec_s4_next = 6'(rem_s3_reg - jdc_pkg::REM_W'(min_s3_reg) * 12'd60);

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            secs_s0_reg <= secs_s0_next;
        end
        if (ctrl.load[1])
        begin
            secs_s1_reg <= secs_s0_reg;
            hour_s1_reg <= hour_s1_next;
        end
        if (ctrl.load[2])
        begin
            hour_s2_reg <= hour_s1_reg;
            rem_s2_reg  <= rem_s2_next;
        end
        if (ctrl.load[3])
        begin
            hour_s3_reg <= hour_s2_reg;
            rem_s3_reg  <= rem_s2_reg;
            min_s3_reg  <= min_s3_next;
        end
        if (ctrl.load[4])
        begin
            hour_dly_reg[4] <= hour_s3_reg;
            min_dly_reg[4]  <= min_s3_reg;
            sec_dly_reg[4]  <= sec_s4_next;
        end
        for (int i = 5; i < N; i++)
        begin
            if (ctrl.load[i])
            begin
                hour_dly_reg[i] <= hour_dly_reg[i-1];
                min_dly_reg[i]  <= min_dly_reg[i-1];
                sec_dly_reg[i]  <= sec_dly_reg[i-1];
            end
        end
    end

    assign hour   = hour_dly_reg[N-1];
    assign minute = min_dly_reg[N-1];
    assign second = sec_dly_reg[N-1];

endmodule

`default_nettype wire

@@ dv/jdc_calendar_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the Julian day to calendar date unit: watches both stream channels,
// predicts each date and time of day, and compares every output transaction with it.
// Depends on jdc_pkg for the field widths and calendar constants.

module jdc_calendar_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // [22:0] day_number, [39:23] second_of_day
    input  wire logic [39:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // [15:0] year, [19:16] month, [24:20] day, [29:25] hour, [35:30] minute,
    // [41:36] second, [47:42] zero
    input  wire logic [47:0] m_tdata,
    output int               fail_count,
    output int               pending_count
);

    localparam int MAX_REPORTS = 10;
    localparam int YEAR_W      = jdc_pkg::YEAR_W;
    localparam int MONTH_W     = jdc_pkg::MONTH_W;
    localparam int DAY_W       = jdc_pkg::DAY_W;
    localparam int HOUR_W      = jdc_pkg::HOUR_W;
    localparam int MINUTE_W    = jdc_pkg::MINUTE_W;
    localparam int SECOND_W    = jdc_pkg::SECOND_W;

    typedef struct packed {
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic [HOUR_W-1:0]        hour;
        logic [MINUTE_W-1:0]      minute;
        logic [SECOND_W-1:0]      second;
    } date_time_t;

    date_time_t expected_dates[$];
    int         errors = 0;

    // Julian calendar before the switch day, Gregorian from it on, no year zero.
    // All quotients are floors of non-negative numerators.
    function automatic date_time_t civil_from_day(
        input logic [jdc_pkg::DAY_NUMBER_W-1:0]    jday,
        input logic [jdc_pkg::SECOND_OF_DAY_W-1:0] secs_in);
        longint     jn, alpha, ja, jb, jc, jd, je, dd, mm, yy;
        int         secs;
        date_time_t r;
        jn = longint'(jday);
        if (jday >= jdc_pkg::GREG_SWITCH_DAY)
        begin
            alpha = (4 * (jn - 1867216) - 1) / 146097;
            ja    = jn + 1 + alpha - alpha / 4;
        end
        else
        begin
            ja = jn;
        end
        jb = ja + 1524;
        jc = (100 * jb - 12210) / 36525;
        jd = 365 * jc + jc / 4;
        je = (10000 * (jb - jd)) / 306001;
        dd = jb - jd - (306001 * je) / 10000;
        mm = je - 1;
        if (mm > 12)
            mm = mm - 12;
        yy = jc - 4715;
        if (mm > 2)
            yy = yy - 1;
        if (yy <= 0)
            yy = yy - 1;
        // Seconds past the end of the day stick at 23:59:59 on the same date.
        secs = (secs_in > jdc_pkg::LAST_SECOND) ? int'(jdc_pkg::LAST_SECOND) : int'(secs_in);
        r.year   = yy[YEAR_W-1:0];
        r.month  = mm[MONTH_W-1:0];
        r.day    = dd[DAY_W-1:0];
        r.hour   = HOUR_W'(secs / 3600);
        r.minute = MINUTE_W'((secs % 3600) / 60);
        r.second = SECOND_W'(secs % 60);
        return r;
    endfunction

    always @(posedge clk)
    begin
        date_time_t want, got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.year   = m_tdata[15:0];
                got.month  = m_tdata[19:16];
                got.day    = m_tdata[24:20];
                got.hour   = m_tdata[29:25];
                got.minute = m_tdata[35:30];
                got.second = m_tdata[41:36];
                if (expected_dates.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: output transaction with nothing outstanding: %0d-%0d-%0d",
                                 $realtime, got.year, got.month, got.day);
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (got.year !== want.year || got.month !== want.month ||
                        got.day !== want.day || got.hour !== want.hour ||
                        got.minute !== want.minute || got.second !== want.second)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display({"%0t: mismatch, expected %0d-%0d-%0d %0d:%0d:%0d,",
                                      " got %0d-%0d-%0d %0d:%0d:%0d"},
                                     $realtime, want.year, want.month, want.day, want.hour,
                                     want.minute, want.second, got.year, got.month, got.day,
                                     got.hour, got.minute, got.second);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_dates.push_back(civil_from_day(s_tdata[22:0], s_tdata[39:23]));
        end
        fail_count    <= errors;
        pending_count <= expected_dates.size();
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Top of the testbench for the Julian day to calendar date unit: clock, reset, stimulus
// with bursty input and a stalling output side, the verdict and a stall watchdog.
// Depends on jdc_pkg, julian_day_to_calendar_date_unit and jdc_calendar_checker.

module testbench;

    localparam int RANDOM_ITEMS    = 700;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int STALL_LIMIT     = 2000;
    localparam int JDAY_W          = jdc_pkg::DAY_NUMBER_W;
    localparam int SECS_W          = jdc_pkg::SECOND_OF_DAY_W;

    typedef enum int {RX_STREAM, RX_RANDOM, RX_PERIODIC} rx_mode_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    int          fail_count;
    int          pending_count;

    // Timestamps to send, packed as they travel on the input channel.
    logic [39:0] timestamps[$];

    julian_day_to_calendar_date_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    jdc_calendar_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_axis_tvalid),
        .s_tready      (s_axis_tready),
        .s_tdata       (s_axis_tdata),
        .m_tvalid      (m_axis_tvalid),
        .m_tready      (m_axis_tready),
        .m_tdata       (m_axis_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic add_timestamp(input int jday, input int secs);
        timestamps.push_back({SECS_W'(secs), JDAY_W'(jday)});
    endtask

    // Sender: a directed set first, then random timestamps, offered in bursts of
    // random length separated by random gaps. Some bursts follow each other with
    // no gap at all, so back-to-back transactions are exercised as well.
    initial
    begin : sender
        int idx, burst, gap, k, pick, jday, secs;
        // Extremes of both fields, both sides of the calendar switch, the years
        // either side of the missing year zero, leap and non-leap February ends,
        // and seconds that saturate.
        add_timestamp(0, 0);
        add_timestamp(1, 1);
        add_timestamp(8388607, 86399);
        add_timestamp(8388606, 131071);
        add_timestamp(2299159, 43200);
        add_timestamp(2299160, 3599);
        add_timestamp(2299161, 3600);
        add_timestamp(2299162, 59);
        add_timestamp(1721057, 60);
        add_timestamp(1721058, 86398);
        add_timestamp(1721423, 86400);
        add_timestamp(1721424, 100000);
        add_timestamp(2451604, 45296);
        add_timestamp(2451605, 61);
        add_timestamp(2415079, 7199);
        add_timestamp(2415080, 7200);
        add_timestamp(2440587, 82800);
        add_timestamp(4194303, 65535);
        add_timestamp(4194304, 65536);
        add_timestamp(5592405, 43690);
        add_timestamp(2796202, 87381);
        for (idx = 0; idx < RANDOM_ITEMS; idx++)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 3)
                jday = $urandom_range(0, 8388607);
            else if (pick <= 5)
                jday = $urandom_range(2299161 - 2000, 2299161 + 2000);
            else if (pick == 6)
                jday = $urandom_range(1721423 - 800, 1721423 + 800);
            else
                jday = $urandom_range(2400000, 2500000);
            if ($urandom_range(0, 7) == 0)
                secs = $urandom_range(86400, 131071);
            else
                secs = $urandom_range(0, 86399);
            add_timestamp(jday, secs);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idx = 0;
        while (idx < timestamps.size())
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst = $urandom_range(1, 32);
            for (k = 0; k < burst && idx < timestamps.size(); k++)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= timestamps[idx];
                @(posedge clk);
                while (!s_axis_tready)
                    @(posedge clk);
                idx++;
            end
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);

        // Drain: every transaction in flight must come out, then allow a few
        // pipeline lengths for anything spurious to show up.
        while (pending_count != 0)
            @(posedge clk);
        repeat (2 * jdc_pkg::NUM_STAGES + 4) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver: segments of random length, each with its own ready pattern. The
    // fourth segment is one long hold-off, long enough for the pipeline to fill
    // and push back on the sender, which keeps offering transactions meanwhile.
    initial
    begin : receiver
        int       seg, len, n;
        rx_mode_t mode;
        wait (rst_n);
        seg = 0;
        forever
        begin
            seg++;
            if (seg == 4)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                mode = rx_mode_t'($urandom_range(0, 2));
                len  = $urandom_range(16, 96);
                for (n = 0; n < len; n++)
                begin
                    unique case (mode)
                        RX_STREAM:   m_axis_tready <= 1'b1;
                        RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 1) == 1);
                        RX_PERIODIC: m_axis_tready <= (n % 5 < 3);
                        default:     m_axis_tready <= 1'b1;
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // Watchdog: ends the run if no transaction moves on either channel for too long.
    initial
    begin : watchdog
        int idle;
        idle = 0;
        wait (rst_n);
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ julian_day_to_calendar_date_unit.f @@
sv/jdc_pkg.sv
sv/jdc_pipe_ctrl.sv
sv/jdc_date_path.sv
sv/jdc_time_path.sv
sv/julian_day_to_calendar_date_unit.sv
dv/jdc_calendar_checker.sv
dv/testbench.sv
